### hw/rtl/sato_pkg.sv
// Shared types and constants for the six-axis tare block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package sato_pkg;

	localparam int NCH  = 6;
	localparam int CH_W = $clog2(NCH);

	localparam int TARE_SAMPLES_RESET = 100;

	localparam logic [1:0] OP_STORE = 2'd0;
	localparam logic [1:0] OP_TARE  = 2'd1;

	localparam logic [2:0] ST_PLAIN    = 3'd0;
	localparam logic [2:0] ST_ACCUM    = 3'd1;
	localparam logic [2:0] ST_DONE     = 3'd2;
	localparam logic [2:0] ST_NO_DATA  = 3'd3;
	localparam logic [2:0] ST_ZERO_CNT = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_sample;
		logic       clear_off;
		logic       inc_steps;
		logic       set_done;
		logic       div_init;
		logic       div_step;
		logic       acc_step;
		logic       load_out;
		logic [2:0] status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic have_sample;
		logic tare_done;
		logic steps_zero;
		logic steps_below;
		logic out_busy;
	} stat_t;

endpackage

### hw/rtl/sato_ctrl.sv
// Controller state machine of the six-axis tare block.
// Depends on sato_pkg; drives the datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps

module sato_ctrl
	import sato_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  stat_t      stat,
	output cmd_t       cmd
);

	localparam int BIT_W = $clog2(SAMPLE_WIDTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV_INIT,
		S_DIV_RUN,
		S_ACC
	} state_t;

	logic              view_pend_q;
	state_t            state_q;
	logic [BIT_W-1:0]  bit_q;
	logic [CH_W-1:0]   ch_q;
	logic [2:0]        status_q;
	logic              accept;
	logic              tare_go;
	logic [2:0]        plain_status;

	assign accept       = in_valid && in_ready;
	assign in_ready     = (state_q == S_IDLE) && !view_pend_q;
	assign plain_status = stat.tare_done ? ST_DONE : ST_PLAIN;
	assign tare_go      = accept && (opcode == OP_TARE) && !stat.count_zero
		&& stat.have_sample && !stat.tare_done;

	always_comb begin
		cmd             = '0;
		cmd.status      = status_q;
		cmd.load_sample = accept && (opcode == OP_STORE);
		cmd.clear_off   = tare_go && stat.steps_zero;
		cmd.inc_steps   = tare_go && stat.steps_below;
		cmd.set_done    = tare_go && !stat.steps_below;
		cmd.div_init    = (state_q == S_DIV_INIT);
		cmd.div_step    = (state_q == S_DIV_RUN);
		cmd.acc_step    = (state_q == S_ACC);
		cmd.load_out    = (state_q == S_IDLE) && view_pend_q && !stat.out_busy;
	end

	// The result beat is loaded from the idle state once the state update is complete.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			view_pend_q <= 1'b0;
			bit_q       <= '0;
			ch_q        <= '0;
			status_q    <= ST_PLAIN;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load_out) begin
						view_pend_q <= 1'b0;
					end
					if (accept) begin
						ch_q <= '0;
						if (opcode == OP_TARE) begin
							if (stat.count_zero) begin
								status_q    <= ST_ZERO_CNT;
								view_pend_q <= 1'b1;
							end else if (!stat.have_sample) begin
								status_q    <= ST_NO_DATA;
								view_pend_q <= 1'b1;
							end else if (stat.tare_done || !stat.steps_below) begin
								status_q    <= ST_DONE;
								view_pend_q <= 1'b1;
							end else begin
								status_q <= ST_ACCUM;
								state_q  <= S_DIV_INIT;
							end
						end else begin
							status_q    <= plain_status;
							view_pend_q <= 1'b1;
						end
					end
				end
				S_DIV_INIT: begin
					bit_q   <= '0;
					state_q <= S_DIV_RUN;
				end
				S_DIV_RUN: begin
					if (bit_q == BIT_W'(SAMPLE_WIDTH - 1)) begin
						state_q <= S_ACC;
					end else begin
						bit_q <= bit_q + 1'b1;
					end
				end
				S_ACC: begin
					if (ch_q == CH_W'(NCH - 1)) begin
						view_pend_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_DIV_INIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("Input accepted while an earlier beat is still at work.");
	a_init_then_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |=> cmd.div_step)
		else $error("Division did not start after its initialisation.");
	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> !cmd.load_out)
		else $error("Result loaded twice for one beat.");
`endif

endmodule

### hw/rtl/sato_dp.sv
// Datapath of the six-axis tare block: sample and offset rotators, the shared
// bit-serial divider, saturating arithmetic and the output register. Uses sato_pkg.
`timescale 1ns / 1ps

module sato_dp
	import sato_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr,
	input  logic [COUNT_WIDTH-1:0]               cfg_data,
	input  logic [NCH-1:0][SAMPLE_WIDTH-1:0]     sample,
	input  cmd_t                                 cmd,
	output stat_t                                stat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [NCH-1:0][SAMPLE_WIDTH-1:0]     comp,
	output logic [2:0]                           status
);

	localparam int W  = SAMPLE_WIDTH;
	localparam int CW = COUNT_WIDTH;

	logic [CW-1:0]              tare_q;
	logic [CW-1:0]              steps_q;
	logic                       done_q;
	logic                       have_q;
	logic [NCH-1:0][W-1:0]      lat_q;
	logic [NCH-1:0][W-1:0]      off_q;
	logic [CW-1:0]              rem_q;
	logic [W-1:0]               quo_q;
	logic                       neg_q;
	logic [NCH-1:0][W-1:0]      comp_q;
	logic [2:0]                 status_q;
	logic                       out_valid_q;

	logic [CW:0]                trial;
	logic                       fits;
	logic [W-1:0]               quot;
	logic [NCH-1:0][W-1:0]      view;

	function automatic logic [W-1:0] sat_fix(input logic [W:0] s);
		logic [W-1:0] res;
		if (s[W] != s[W-1]) begin
			res = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			res = s[W-1:0];
		end
		return res;
	endfunction

	assign stat.count_zero  = (tare_q == '0);
	assign stat.have_sample = have_q;
	assign stat.tare_done   = done_q;
	assign stat.steps_zero  = (steps_q == '0);
	assign stat.steps_below = (steps_q < tare_q);
	assign stat.out_busy    = out_valid_q && !out_ready;

	// Restoring division of the magnitude, one quotient bit a cycle.
	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = (trial >= {1'b0, tare_q});
	assign quot  = neg_q ? (~quo_q + 1'b1) : quo_q;

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			view[i] = done_q
				? sat_fix({lat_q[i][W-1], lat_q[i]} - {off_q[i][W-1], off_q[i]})
				: lat_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q      <= CW'(TARE_SAMPLES_RESET);
			steps_q     <= '0;
			done_q      <= 1'b0;
			have_q      <= 1'b0;
			lat_q       <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				tare_q <= cfg_data;
			end
			if (cmd.load_sample) begin
				lat_q  <= sample;
				have_q <= 1'b1;
			end
			if (cmd.clear_off) begin
				off_q <= '0;
			end
			if (cmd.inc_steps) begin
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.set_done) begin
				done_q <= 1'b1;
			end
			// Channels rotate so that the one being worked on always sits at the head.
			if (cmd.acc_step) begin
				for (int i = 0; i < NCH - 1; i++) begin
					lat_q[i] <= lat_q[i+1];
					off_q[i] <= off_q[i+1];
				end
				lat_q[NCH-1] <= lat_q[0];
				off_q[NCH-1] <= sat_fix({off_q[0][W-1], off_q[0]} + {quot[W-1], quot});
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			neg_q <= lat_q[0][W-1];
			quo_q <= lat_q[0][W-1] ? (~lat_q[0] + 1'b1) : lat_q[0];
		end else if (cmd.div_step) begin
			rem_q <= fits ? trial[CW-1:0] - tare_q : trial[CW-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
		if (cmd.load_out) begin
			comp_q   <= view;
			status_q <= cmd.status;
		end
	end

	assign out_valid = out_valid_q;
	assign comp      = comp_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && !out_ready))
		else $error("Result register overwritten before its beat was taken.");
	a_done_has_sample: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> have_q)
		else $error("Tare done without any sample stored.");
	a_steps_has_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(steps_q != '0) |-> have_q)
		else $error("Tare steps counted without any sample stored.");
`endif

endmodule

### hw/rtl/six_axis_tare_offset.sv
// Top level of the six-axis force/torque tare block.
// Depends on sato_pkg, sato_ctrl and sato_dp.
//
//   Channel  Signals                                   Direction
//   input    in_valid/in_ready, opcode, six samples    in
//   result   out_valid/out_ready, six comp_*, status   out
//   config   cfg_valid/cfg_ready, cfg_data             in
//
// A tare step that accumulates runs the one shared bit-serial divider, which
// serves all six channels, once for each channel in turn. Every other item is
// handled in the idle state. One item is at work at a time; the next is taken
// while the previous result still waits in the output register.
// Reset clears control and tare state, not the result; the count returns to 100.
// A stalled result stalls the block only when the next result is ready to load.
`timescale 1ns / 1ps

module six_axis_tare_offset
	import sato_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     opcode,
	input  logic signed [SAMPLE_WIDTH-1:0] force_x,
	input  logic signed [SAMPLE_WIDTH-1:0] force_y,
	input  logic signed [SAMPLE_WIDTH-1:0] force_z,
	input  logic signed [SAMPLE_WIDTH-1:0] torque_x,
	input  logic signed [SAMPLE_WIDTH-1:0] torque_y,
	input  logic signed [SAMPLE_WIDTH-1:0] torque_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] comp_force_x,
	output logic signed [SAMPLE_WIDTH-1:0] comp_force_y,
	output logic signed [SAMPLE_WIDTH-1:0] comp_force_z,
	output logic signed [SAMPLE_WIDTH-1:0] comp_torque_x,
	output logic signed [SAMPLE_WIDTH-1:0] comp_torque_y,
	output logic signed [SAMPLE_WIDTH-1:0] comp_torque_z,
	output logic [2:0]                     status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [COUNT_WIDTH-1:0]         cfg_data
);

	cmd_t                                cmd;
	stat_t                               stat;
	logic [NCH-1:0][SAMPLE_WIDTH-1:0]    sample;
	logic [NCH-1:0][SAMPLE_WIDTH-1:0]    comp;

	assign cfg_ready = 1'b1;

	assign sample[0] = force_x;
	assign sample[1] = force_y;
	assign sample[2] = force_z;
	assign sample[3] = torque_x;
	assign sample[4] = torque_y;
	assign sample[5] = torque_z;

	assign comp_force_x  = $signed(comp[0]);
	assign comp_force_y  = $signed(comp[1]);
	assign comp_force_z  = $signed(comp[2]);
	assign comp_torque_x = $signed(comp[3]);
	assign comp_torque_y = $signed(comp[4]);
	assign comp_torque_z = $signed(comp[5]);

	sato_ctrl #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.stat     (stat),
		.cmd      (cmd)
	);

	sato_dp #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.comp      (comp),
		.status    (status)
	);

endmodule

### verif/testbench.sv
// Self-checking testbench for the six-axis force/torque tare block.
// Depends on sato_pkg and six_axis_tare_offset; a directed table is followed by
// random beats, checked against typed views or a behavioural tare predictor.
`timescale 1ns / 1ps

module testbench;
	import sato_pkg::*;

	localparam int          SW         = 32;
	localparam int          CW         = 16;
	localparam int          SEG_ITEMS  = 150;
	localparam int          SEGMENTS   = 12;
	localparam int          DONE_SEG   = 6;
	localparam int          TAIL       = 220;
	localparam longint      CYCLE_CAP  = 3000000;
	localparam longint      SAT_HI     = 64'sd2147483647;
	localparam longint      SAT_LO     = -64'sd2147483648;
	localparam logic [31:0] TOP        = 32'h7fffffff;
	localparam logic [31:0] BOTTOM     = 32'h80000000;

	// Read opcodes are not named in the package.
	localparam logic [1:0]  OP_READ    = 2'd2;
	localparam logic [1:0]  OP_SPARE   = 2'd3;

	typedef logic [5:0][SW-1:0] axes_t;

	typedef struct packed {
		axes_t      axes;
		logic [2:0] status;
	} tare_view_t;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t      kind;
		logic [CW-1:0]  cfg_val;
		logic [1:0]     op;
		axes_t          in_axes;
		bit             typed;
		tare_view_t     typed_view;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           opcode = '0;
	logic signed [SW-1:0] force_x = '0;
	logic signed [SW-1:0] force_y = '0;
	logic signed [SW-1:0] force_z = '0;
	logic signed [SW-1:0] torque_x = '0;
	logic signed [SW-1:0] torque_y = '0;
	logic signed [SW-1:0] torque_z = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [SW-1:0] comp_force_x;
	logic signed [SW-1:0] comp_force_y;
	logic signed [SW-1:0] comp_force_z;
	logic signed [SW-1:0] comp_torque_x;
	logic signed [SW-1:0] comp_torque_y;
	logic signed [SW-1:0] comp_torque_z;
	logic [2:0]           status;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CW-1:0]        cfg_data = '0;

	// Predictor state: a copy of what the block should hold.
	axes_t         held_ref = '0;
	axes_t         offs_ref = '0;
	logic [CW-1:0] steps_ref = '0;
	logic [CW-1:0] count_ref = CW'(TARE_SAMPLES_RESET);
	bit            done_ref = 1'b0;
	bit            seen_ref = 1'b0;

	tare_view_t    expected_views [$];
	stim_row_t     dir_rows [$];
	string         axis_names [6] = '{"comp_force_x", "comp_force_y", "comp_force_z",
		"comp_torque_x", "comp_torque_y", "comp_torque_z"};

	int unsigned   send_idle_pct = 0;
	int unsigned   recv_idle_pct = 0;
	int unsigned   view_errors = 0;
	int unsigned   items_sent = 0;
	int unsigned   tare_beats = 0;
	int unsigned   results_seen = 0;
	int unsigned   count_writes = 0;
	longint        cycle_count = 0;

	six_axis_tare_offset #(
		.SAMPLE_WIDTH(SW),
		.COUNT_WIDTH (CW)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.force_x      (force_x),
		.force_y      (force_y),
		.force_z      (force_z),
		.torque_x     (torque_x),
		.torque_y     (torque_y),
		.torque_z     (torque_z),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.comp_force_x (comp_force_x),
		.comp_force_y (comp_force_y),
		.comp_force_z (comp_force_z),
		.comp_torque_x(comp_torque_x),
		.comp_torque_y(comp_torque_y),
		.comp_torque_z(comp_torque_z),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic axes_t axes(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
			logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
		axes_t a;
		a[0] = fx;
		a[1] = fy;
		a[2] = fz;
		a[3] = tx;
		a[4] = ty;
		a[5] = tz;
		return a;
	endfunction

	function automatic logic [SW-1:0] clamp_sample(longint v);
		if (v > SAT_HI) begin
			return SAT_HI[SW-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[SW-1:0];
		end
		return v[SW-1:0];
	endfunction

	// Applies one beat to the predictor state and returns the view it should produce.
	function automatic tare_view_t predict_view(logic [1:0] op, axes_t smp);
		tare_view_t r;
		longint     divisor;
		longint     acc;
		longint     cur;
		int         i;
		r.status = done_ref ? ST_DONE : ST_PLAIN;
		case (op)
			OP_STORE: begin
				held_ref = smp;
				seen_ref = 1'b1;
			end
			OP_TARE: begin
				if (count_ref == '0) begin
					r.status = ST_ZERO_CNT;
				end else if (!seen_ref) begin
					r.status = ST_NO_DATA;
				end else if (done_ref) begin
					r.status = ST_DONE;
				end else begin
					if (steps_ref == '0) begin
						offs_ref = '0;
					end
					if (steps_ref < count_ref) begin
						divisor = count_ref;
						for (i = 0; i < 6; i++) begin
							acc = $signed(offs_ref[i]);
							cur = $signed(held_ref[i]);
							offs_ref[i] = clamp_sample(acc + cur / divisor);
						end
						steps_ref = steps_ref + 1'b1;
						r.status = ST_ACCUM;
					end else begin
						done_ref = 1'b1;
						r.status = ST_DONE;
					end
				end
			end
			default: begin
			end
		endcase
		for (i = 0; i < 6; i++) begin
			if (done_ref) begin
				acc = $signed(held_ref[i]);
				cur = $signed(offs_ref[i]);
				r.axes[i] = clamp_sample(acc - cur);
			end else begin
				r.axes[i] = held_ref[i];
			end
		end
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CW-1:0] val);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.cfg_val = val;
		return row;
	endfunction

	function automatic stim_row_t item_row(logic [1:0] op, axes_t a);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.op = op;
		row.in_axes = a;
		return row;
	endfunction

	function automatic stim_row_t typed_row(logic [1:0] op, axes_t a, axes_t want,
			logic [2:0] st);
		stim_row_t row;
		row = item_row(op, a);
		row.typed = 1'b1;
		row.typed_view.axes = want;
		row.typed_view.status = st;
		return row;
	endfunction

	function automatic axes_t random_axes();
		axes_t a;
		int    i;
		for (i = 0; i < 6; i++) begin
			case ($urandom_range(7))
				0: a[i] = TOP;
				1: a[i] = BOTTOM;
				2: a[i] = '0;
				3: a[i] = $urandom_range(131072) - 65536;
				default: a[i] = $urandom();
			endcase
		end
		return a;
	endfunction

	// Waits until every expected result has come back; the input is parked first.
	task automatic drain_views();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_views.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_count(logic [CW-1:0] val);
		drain_views();
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		count_ref = val;
		count_writes++;
	endtask

	task automatic send_item(logic [1:0] op, axes_t smp, bit typed, tare_view_t typed_view);
		tare_view_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		force_x <= smp[0];
		force_y <= smp[1];
		force_z <= smp[2];
		torque_x <= smp[3];
		torque_y <= smp[4];
		torque_z <= smp[5];
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		pred = predict_view(op, smp);
		expected_views.push_back(typed ? typed_view : pred);
		items_sent++;
		if (op == OP_TARE) begin
			tare_beats++;
		end
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_views.size());
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin : check_views
		tare_view_t want;
		tare_view_t got;
		int         i;
		if (arst_n && out_valid && out_ready) begin
			got.axes = axes(comp_force_x, comp_force_y, comp_force_z,
				comp_torque_x, comp_torque_y, comp_torque_z);
			got.status = status;
			if (expected_views.size() == 0) begin
				view_errors++;
				if (view_errors <= 10) begin
					$display("result beat with nothing expected, status %0d", got.status);
				end
			end else begin
				want = expected_views.pop_front();
				results_seen++;
				for (i = 0; i < 6; i++) begin
					if (got.axes[i] !== want.axes[i]) begin
						view_errors++;
						if (view_errors <= 10) begin
							$display("result %0d %0s: expected %0d, got %0d", results_seen,
								axis_names[i], $signed(want.axes[i]), $signed(got.axes[i]));
						end
					end
				end
				if (got.status !== want.status) begin
					view_errors++;
					if (view_errors <= 10) begin
						$display("result %0d status: expected %0d, got %0d", results_seen,
							want.status, got.status);
					end
				end
			end
		end
	end

	initial begin
		axes_t      ext;
		axes_t      alt;
		axes_t      smp;
		logic [1:0] op;
		int         seg;
		int         k;
		int         pick;
		int         i;

		ext = axes(TOP, BOTTOM, TOP, BOTTOM, 32'd1, 32'hffffffff);
		alt = axes(BOTTOM, TOP, 32'd0, 32'hffffffff, 32'h7fff0000, 32'h12345678);

		// Zero count is checked ahead of missing data, and opcode 3 reads.
		dir_rows.push_back(typed_row(OP_READ, '0, '0, ST_PLAIN));
		dir_rows.push_back(typed_row(OP_TARE, '0, '0, ST_NO_DATA));
		dir_rows.push_back(cfg_row('0));
		dir_rows.push_back(typed_row(OP_TARE, '0, '0, ST_ZERO_CNT));
		dir_rows.push_back(typed_row(OP_STORE, ext, ext, ST_PLAIN));
		dir_rows.push_back(typed_row(OP_TARE, '1, ext, ST_ZERO_CNT));
		dir_rows.push_back(typed_row(OP_SPARE, alt, ext, ST_PLAIN));
		// A count of one takes the whole sample; raising the count mid-tare then
		// pushes the offsets into saturation.
		dir_rows.push_back(cfg_row(CW'(1)));
		dir_rows.push_back(item_row(OP_TARE, '0));
		dir_rows.push_back(cfg_row('1));
		dir_rows.push_back(item_row(OP_TARE, '0));
		dir_rows.push_back(item_row(OP_STORE, alt));
		dir_rows.push_back(item_row(OP_TARE, alt));
		dir_rows.push_back(item_row(OP_READ, '1));
		dir_rows.push_back(item_row(OP_STORE, axes(32'hffff0000, 32'h0000ffff, 32'h00010000,
			32'h80000001, 32'h7ffffffe, 32'h55555555)));
		dir_rows.push_back(item_row(OP_TARE, '0));
		dir_rows.push_back(item_row(OP_STORE, '0));
		dir_rows.push_back(item_row(OP_TARE, '0));
		dir_rows.push_back(item_row(OP_READ, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 83;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				write_count(dir_rows[r].cfg_val);
			end else begin
				send_item(dir_rows[r].op, dir_rows[r].in_axes, dir_rows[r].typed,
					dir_rows[r].typed_view);
			end
		end

		for (seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 4) begin
				send_idle_pct = 30;
				recv_idle_pct = 83;
			end else if (seg < 8) begin
				send_idle_pct = 83;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			pick = $urandom_range(3);
			if (seg < DONE_SEG) begin
				// A zero count, or one well above the steps taken so the tare keeps averaging.
				if (pick == 0) begin
					write_count('0);
				end else if (pick == 1) begin
					write_count('1);
				end else begin
					write_count(CW'($urandom_range(65535, steps_ref + 200)));
				end
			end else if (seg == DONE_SEG) begin
				// Dropping the count to or below the steps taken latches done on the next step.
				write_count(CW'($urandom_range(steps_ref, 1)));
			end else begin
				case (pick)
					0: write_count('0);
					1: write_count(CW'(1));
					2: write_count('1);
					default: write_count(CW'($urandom_range(65535)));
				endcase
			end
			for (k = 0; k < SEG_ITEMS; k++) begin
				if ($urandom_range(49) == 0) begin
					drain_views();
				end
				i = $urandom_range(99);
				if (i < 35) begin
					op = OP_STORE;
				end else if (i < 75) begin
					op = OP_TARE;
				end else if (i < 95) begin
					op = OP_READ;
				end else begin
					op = OP_SPARE;
				end
				smp = random_axes();
				send_item(op, smp, 1'b0, '0);
			end
		end

		drain_views();
		repeat (TAIL) @(posedge clk);
		if (expected_views.size() != 0) begin
			view_errors += expected_views.size();
		end
		$display("Covered %0d beats (%0d tare steps) over %0d count settings and three",
			items_sent, tare_beats, count_writes);
		$display("idling patterns; %0d results checked, tare done reached: %0d, errors: %0d",
			results_seen, done_ref, view_errors);
		if (view_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
